// File: rtl/core/nfe_pkg.sv
// Package: shared types, constants and fixed-point helpers of the force estimator.
package nfe_pkg;

  localparam int MODEL_MAX_DEF = 64;
  localparam int CLOUD_MAX_DEF = 1024;

  localparam logic [15:0] GAIN_RESET = 16'd256;

  // configuration register indexes
  localparam logic [7:0] REG_GAIN_M2C = 8'd0;
  localparam logic [7:0] REG_GAIN_C2M = 8'd1;
  localparam logic [7:0] REG_GAIN_REG = 8'd2;

  localparam logic signed [64:0] ACC_LIM = 65'sh4000000000000000;
  localparam logic signed [64:0] Q_MAX   = 65'sd2147483647;
  localparam logic signed [64:0] Q_MIN   = -65'sd2147483648;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT_A,
    OP_INIT_B,
    OP_CAPTURE,
    OP_SHIFT
  } cell_op_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_op_t           op;
    logic [8:0]         n_count;
    logic               no_cloud;
    logic [15:0]        g_m2c;
    logic [15:0]        g_c2m;
    logic [15:0]        g_reg;
    logic               wr_en;
    logic [7:0]         wr_idx;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic signed [31:0] wpx;
    logic signed [31:0] wpy;
    logic signed [31:0] wpz;
    logic               whid;
  } ctrl_t;

  // cloud point moving down the chain with its running nearest model point
  typedef struct packed {
    logic               pt_valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               best_valid;
    logic [65:0]        best_d;
    logic [7:0]         best_idx;
  } srch_t;

  // cloud-to-model pull addressed to one cell
  typedef struct packed {
    logic               valid;
    logic [7:0]         idx;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } req_t;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } force_t;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] r;
    r = 65'(a) + 65'(b);
    if (r > ACC_LIM) r = ACC_LIM;
    if (r < -ACC_LIM) r = -ACC_LIM;
    return r[63:0];
  endfunction

  // round to 16 fraction bits and saturate to 32 bits
  function automatic logic signed [31:0] finish(logic signed [63:0] acc);
    logic signed [64:0] v;
    logic signed [64:0] q;
    v = 65'(acc) + 65'sd128;
    q = v >>> 8;
    if (q > Q_MAX) return 32'sh7fffffff;
    if (q < Q_MIN) return 32'sh80000000;
    return q[31:0];
  endfunction

endpackage

// File: rtl/core/nfe_in_if.sv
// Interface: input item channel.
interface nfe_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] prev_z;
  logic               occluded;
  logic               last;
  modport source (output valid, mode, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z,
                  occluded, last, input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, prev_x, prev_y, prev_z,
                occluded, last, output ready);
endinterface

// File: rtl/core/nfe_out_if.sv
// Interface: result item channel.
interface nfe_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         point_index;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic               final_res;
  modport source (output valid, point_index, force_x, force_y, force_z, final_res,
                  input ready);
  modport sink (input valid, point_index, force_x, force_y, force_z, final_res,
                output ready);
endinterface

// File: rtl/core/nfe_cfg_if.sv
// Interface: configuration write channel.
interface nfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/nearest_point_force_estimator_unit.sv
// Top level: nearest-point force estimator built as a chain of model-point cells.
// Model items are written straight into their cell and cloud items into a cloud
// memory, one transfer per cycle. The cloud item marked last starts a frame:
// every stored cloud point streams down the cell chain (one point a cycle,
// through both search stages of each cell), each cell keeping its own
// nearest cloud point while the point carries its nearest model index to
// the end, where it is logged. The cells then form the model-to-cloud and
// regularization terms, the logged cloud-to-model pulls stream down the
// chain again, and the forces shift out of cell 0 in index order. A frame
// makes two passes of the cloud memory read through the chain. Input is
// not taken during a frame; results then leave at one per cycle under
// out_ch.ready.
module nearest_point_force_estimator_unit #(
  parameter int MODEL_MAX = nfe_pkg::MODEL_MAX_DEF,
  parameter int CLOUD_MAX = nfe_pkg::CLOUD_MAX_DEF
) (
  input logic      clk,
  input logic      rst_n,
  nfe_in_if.sink   in_ch,
  nfe_out_if.source out_ch,
  nfe_cfg_if.sink  cfg_ch
);
  import nfe_pkg::*;

  localparam int MW  = $clog2(MODEL_MAX + 1);
  localparam int IW  = $clog2(MODEL_MAX);
  localparam int CW  = $clog2(CLOUD_MAX + 1);
  localparam int CAW = (CLOUD_MAX > 1) ? $clog2(CLOUD_MAX) : 1;
  localparam int DW  = $clog2(MODEL_MAX + 4);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SEARCH, S_INIT_A, S_INIT_B,
    S_REPLAY, S_DRAIN, S_CAPTURE, S_OUT
  } state_t;

  state_t      state_r;
  logic [MW-1:0] m_cnt_r, emit_r;
  logic [CW-1:0] c_cnt_r, rd_r, wr_r;
  logic [DW-1:0] wait_r;
  logic          rd_vld_r;
  logic [15:0]   g_m2c_r, g_c2m_r, g_reg_r;

  logic [95:0]   cloud_mem [CLOUD_MAX];
  logic [IW-1:0] bidx_mem [CLOUD_MAX];
  logic [95:0]   cl_q_r;
  logic [IW-1:0] bidx_q_r;

  logic          out_valid_r, out_final_r;
  logic [5:0]    out_idx_r;
  force_t        out_force_r;

  ctrl_t  ctrl;
  srch_t  srch_link [MODEL_MAX+1];
  req_t   req_link  [MODEL_MAX+1];
  force_t out_link  [MODEL_MAX+1];

  logic in_xfer, model_wr, cloud_wr, shift_go;
  logic [8:0] emit9;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign model_wr = in_xfer && !in_ch.mode && (m_cnt_r < MW'(MODEL_MAX));
  assign cloud_wr = in_xfer && in_ch.mode && (c_cnt_r < CW'(CLOUD_MAX));
  assign shift_go = (state_r == S_OUT) && (emit_r < m_cnt_r) &&
                    (!out_valid_r || out_ch.ready);
  assign emit9 = 9'(emit_r);

  // gains; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_m2c_r <= GAIN_RESET;
      g_c2m_r <= GAIN_RESET;
      g_reg_r <= GAIN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_GAIN_M2C: g_m2c_r <= cfg_ch.data;
        REG_GAIN_C2M: g_c2m_r <= cfg_ch.data;
        REG_GAIN_REG: g_reg_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // cloud store and nearest-model log; registered reads
  always_ff @(posedge clk) begin
    if (cloud_wr) cloud_mem[c_cnt_r[CAW-1:0]] <= {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z};
    if (srch_link[MODEL_MAX].pt_valid)
      bidx_mem[wr_r[CAW-1:0]] <= srch_link[MODEL_MAX].best_idx[IW-1:0];
    cl_q_r   <= cloud_mem[rd_r[CAW-1:0]];
    bidx_q_r <= bidx_mem[rd_r[CAW-1:0]];
  end

  // broadcast control
  always_comb begin
    ctrl.op = OP_NONE;
    case (state_r)
      S_START:   ctrl.op = OP_CLEAR;
      S_INIT_A:  ctrl.op = OP_INIT_A;
      S_INIT_B:  ctrl.op = OP_INIT_B;
      S_CAPTURE: ctrl.op = OP_CAPTURE;
      S_OUT:     ctrl.op = shift_go ? OP_SHIFT : OP_NONE;
      default:   ctrl.op = OP_NONE;
    endcase
    ctrl.n_count  = 9'(m_cnt_r);
    ctrl.no_cloud = (c_cnt_r == '0);
    ctrl.g_m2c    = g_m2c_r;
    ctrl.g_c2m    = g_c2m_r;
    ctrl.g_reg    = g_reg_r;
    ctrl.wr_en    = model_wr;
    ctrl.wr_idx   = 8'(m_cnt_r);
    ctrl.wx       = in_ch.pos_x;
    ctrl.wy       = in_ch.pos_y;
    ctrl.wz       = in_ch.pos_z;
    ctrl.wpx      = in_ch.prev_x;
    ctrl.wpy      = in_ch.prev_y;
    ctrl.wpz      = in_ch.prev_z;
    ctrl.whid     = in_ch.occluded;
  end

  // chain heads: search pass and pull pass share the memory read
  always_comb begin
    srch_link[0].pt_valid   = rd_vld_r && (state_r == S_SEARCH);
    srch_link[0].px         = cl_q_r[95:64];
    srch_link[0].py         = cl_q_r[63:32];
    srch_link[0].pz         = cl_q_r[31:0];
    srch_link[0].best_valid = 1'b0;
    srch_link[0].best_d     = '0;
    srch_link[0].best_idx   = '0;
    req_link[0].valid = rd_vld_r && (state_r == S_REPLAY || state_r == S_DRAIN);
    req_link[0].idx   = 8'(bidx_q_r);
    req_link[0].cx    = cl_q_r[95:64];
    req_link[0].cy    = cl_q_r[63:32];
    req_link[0].cz    = cl_q_r[31:0];
    out_link[MODEL_MAX] = '0;
  end

  for (genvar k = 0; k < MODEL_MAX; k++) begin : g_cell
    nfe_cell #(.CELL_IDX(8'(k))) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .srch_i (srch_link[k]),
      .srch_o (srch_link[k+1]),
      .req_i  (req_link[k]),
      .req_o  (req_link[k+1]),
      .out_i  (out_link[k+1]),
      .out_o  (out_link[k])
    );
  end

  // frame sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      m_cnt_r     <= '0;
      c_cnt_r     <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      emit_r      <= '0;
      wait_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= (state_r == S_SEARCH || state_r == S_REPLAY) && (rd_r < c_cnt_r);
      out_valid_r <= shift_go || (out_valid_r && !out_ch.ready);
      case (state_r)
        S_IDLE: begin
          if (model_wr) m_cnt_r <= m_cnt_r + 1'b1;
          if (cloud_wr) c_cnt_r <= c_cnt_r + 1'b1;
          if (in_xfer && in_ch.mode && in_ch.last) state_r <= S_START;
        end
        S_START: begin
          rd_r <= '0;
          wr_r <= '0;
          if (m_cnt_r == '0) begin
            c_cnt_r <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (rd_r < c_cnt_r) rd_r <= rd_r + 1'b1;
          if (srch_link[MODEL_MAX].pt_valid) wr_r <= wr_r + 1'b1;
          if (wr_r == c_cnt_r) state_r <= S_INIT_A;
        end
        S_INIT_A: begin
          rd_r    <= '0;
          state_r <= S_INIT_B;
        end
        S_INIT_B: state_r <= S_REPLAY;
        S_REPLAY: begin
          if (rd_r < c_cnt_r) begin
            rd_r <= rd_r + 1'b1;
          end else begin
            wait_r  <= DW'(MODEL_MAX + 3);
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          wait_r <= wait_r - 1'b1;
          if (wait_r == '0) state_r <= S_CAPTURE;
        end
        S_CAPTURE: begin
          emit_r  <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (shift_go) begin
            out_idx_r   <= emit9[5:0];
            out_force_r <= out_link[0];
            out_final_r <= (emit_r + 1'b1 == m_cnt_r);
            emit_r      <= emit_r + 1'b1;
          end else if (emit_r == m_cnt_r) begin
            m_cnt_r <= '0;
            c_cnt_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.point_index = out_idx_r;
  assign out_ch.force_x     = out_force_r.fx;
  assign out_ch.force_y     = out_force_r.fy;
  assign out_ch.force_z     = out_force_r.fz;
  assign out_ch.final_res   = out_final_r;

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (emit_r <= m_cnt_r))
    else $error("more forces emitted than model points");

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    srch_link[MODEL_MAX].pt_valid |-> (state_r == S_SEARCH))
    else $error("search result left the chain outside the search pass");

  a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (wr_r <= c_cnt_r))
    else $error("nearest-model log overran the cloud count");

  a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.ready && out_final_r) |=> !out_valid_r)
    else $error("result after the final force of a frame");

endmodule

// File: rtl/core/nfe_cell.sv
// Cell: one model point, its nearest-cloud search, force accumulator and output tap.
module nfe_cell #(
  parameter logic [7:0] CELL_IDX = 8'd0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  nfe_pkg::ctrl_t  ctrl,
  input  nfe_pkg::srch_t  srch_i,
  output nfe_pkg::srch_t  srch_o,
  input  nfe_pkg::req_t   req_i,
  output nfe_pkg::req_t   req_o,
  input  nfe_pkg::force_t out_i,
  output nfe_pkg::force_t out_o
);
  import nfe_pkg::*;

  typedef enum logic [1:0] {K_NONE, K_SET, K_ADD} kind_t;

  logic signed [31:0] m_x_r, m_y_r, m_z_r, p_x_r, p_y_r, p_z_r;
  logic               hid_r;
  logic               active;

  // search stage 1
  srch_t       s1_r;
  logic [63:0] sq_x_r, sq_y_r, sq_z_r;
  logic [31:0] mag_x, mag_y, mag_z;
  logic signed [32:0] dx, dy, dz;
  // search stage 2
  logic [65:0] sq_dist;
  srch_t       srch_r;
  srch_t       srch_nxt;
  logic        own_has_r;
  logic [65:0] own_d_r;
  logic signed [31:0] own_x_r, own_y_r, own_z_r;

  // force path
  logic               hit;
  logic signed [31:0] tx, ty, tz;
  logic [15:0]        gain;
  kind_t              kind, kind_r;
  logic               zero_t;
  logic signed [32:0] ex, ey, ez;
  logic signed [49:0] prx, pry, prz;
  logic signed [63:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [63:0] acc_x_r, acc_y_r, acc_z_r;
  req_t               req_r;
  force_t             out_r;

  assign active = {1'b0, CELL_IDX} < ctrl.n_count;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_idx == CELL_IDX) begin
      m_x_r <= ctrl.wx;  m_y_r <= ctrl.wy;  m_z_r <= ctrl.wz;
      p_x_r <= ctrl.wpx; p_y_r <= ctrl.wpy; p_z_r <= ctrl.wpz;
      hid_r <= ctrl.whid;
    end
  end

  always_comb begin
    dx = {srch_i.px[31], srch_i.px} - {m_x_r[31], m_x_r};
    dy = {srch_i.py[31], srch_i.py} - {m_y_r[31], m_y_r};
    dz = {srch_i.pz[31], srch_i.pz} - {m_z_r[31], m_z_r};
    mag_x = dx[32] ? 32'(-dx) : dx[31:0];
    mag_y = dy[32] ? 32'(-dy) : dy[31:0];
    mag_z = dz[32] ? 32'(-dz) : dz[31:0];
  end

  assign sq_dist = {2'b00, sq_x_r} + {2'b00, sq_y_r} + {2'b00, sq_z_r};

  // strict compare keeps the lower model index on ties
  always_comb begin
    srch_nxt = s1_r;
    if (s1_r.pt_valid && active && (!s1_r.best_valid || sq_dist < s1_r.best_d)) begin
      srch_nxt.best_valid = 1'b1;
      srch_nxt.best_d     = sq_dist;
      srch_nxt.best_idx   = CELL_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.pt_valid   <= 1'b0;
      srch_r.pt_valid <= 1'b0;
      own_has_r       <= 1'b0;
    end else begin
      s1_r   <= srch_i;
      sq_x_r <= mag_x * mag_x;
      sq_y_r <= mag_y * mag_y;
      sq_z_r <= mag_z * mag_z;
      srch_r <= srch_nxt;
      if (ctrl.op == OP_CLEAR) begin
        own_has_r <= 1'b0;
      end else if (s1_r.pt_valid && active && (!own_has_r || sq_dist < own_d_r)) begin
        own_has_r <= 1'b1;
        own_d_r   <= sq_dist;
        own_x_r   <= s1_r.px;
        own_y_r   <= s1_r.py;
        own_z_r   <= s1_r.pz;
      end
    end
  end

  assign srch_o = srch_r;

  // operand select for the shared gain multipliers
  always_comb begin
    hit    = req_i.valid && req_i.idx == CELL_IDX;
    tx     = p_x_r; ty = p_y_r; tz = p_z_r;
    gain   = ctrl.g_reg;
    kind   = K_NONE;
    zero_t = 1'b0;
    if (hit) begin
      tx = req_i.cx; ty = req_i.cy; tz = req_i.cz;
      gain = ctrl.g_c2m;
      kind = K_ADD;
    end else begin
      case (ctrl.op)
        OP_INIT_A: begin
          tx = own_x_r; ty = own_y_r; tz = own_z_r;
          gain   = ctrl.g_m2c;
          kind   = K_SET;
          zero_t = hid_r || ctrl.no_cloud;
        end
        OP_INIT_B: begin
          kind = hid_r ? K_NONE : K_ADD;
        end
        default: kind = K_NONE;
      endcase
    end
    ex  = {tx[31], tx} - {m_x_r[31], m_x_r};
    ey  = {ty[31], ty} - {m_y_r[31], m_y_r};
    ez  = {tz[31], tz} - {m_z_r[31], m_z_r};
    prx = ex * $signed({1'b0, gain});
    pry = ey * $signed({1'b0, gain});
    prz = ez * $signed({1'b0, gain});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= K_NONE;
      req_r.valid <= 1'b0;
    end else begin
      kind_r   <= kind;
      prod_x_r <= zero_t ? 64'sd0 : 64'(prx);
      prod_y_r <= zero_t ? 64'sd0 : 64'(pry);
      prod_z_r <= zero_t ? 64'sd0 : 64'(prz);
      req_r    <= req_i;
      case (kind_r)
        K_SET: begin
          acc_x_r <= prod_x_r; acc_y_r <= prod_y_r; acc_z_r <= prod_z_r;
        end
        K_ADD: begin
          acc_x_r <= sat_add(acc_x_r, prod_x_r);
          acc_y_r <= sat_add(acc_y_r, prod_y_r);
          acc_z_r <= sat_add(acc_z_r, prod_z_r);
        end
        default: ;
      endcase
    end
  end

  assign req_o = req_r;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CAPTURE: begin
        out_r.fx <= finish(acc_x_r);
        out_r.fy <= finish(acc_y_r);
        out_r.fz <= finish(acc_z_r);
      end
      OP_SHIFT: out_r <= out_i;
      default: ;
    endcase
  end

  assign out_o = out_r;

endmodule

// File: bench/tb_nearest_point_force_estimator_unit.sv
// Testbench for the nearest-point force estimator: directed and random frames checked against a predictor.
`timescale 1ns / 1ps
module tb_nearest_point_force_estimator_unit;
  import nfe_pkg::*;

  // one input transfer as the predictor sees it
  typedef struct {
    logic               mode;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] qx, qy, qz;
    logic               occluded;
    logic               last;
  } point_item_t;

  // one force result
  typedef struct packed {
    logic [5:0]         idx;
    logic signed [31:0] fx, fy, fz;
    logic               fin;
  } force_rec_t;

  localparam longint ACC_SAT = 64'sh4000000000000000;

  // Tracks the loaded frame, solves it when the last cloud point lands and
  // checks forces in order.
  class force_tracker;
    logic [15:0]  g_m2c, g_c2m, g_reg;
    point_item_t  model_pts[$];
    point_item_t  cloud_pts[$];
    force_rec_t   expected_forces[$];
    int           mismatches;

    function new();
      g_m2c = GAIN_RESET;
      g_c2m = GAIN_RESET;
      g_reg = GAIN_RESET;
      mismatches = 0;
    endfunction

    function void set_gain(logic [7:0] idx, logic [15:0] v);
      if (idx == REG_GAIN_M2C) g_m2c = v;
      else if (idx == REG_GAIN_C2M) g_c2m = v;
      else if (idx == REG_GAIN_REG) g_reg = v;
    endfunction

    function int pending();
      return expected_forces.size();
    endfunction

    // exact squared distance
    function logic [67:0] dist_sq(point_item_t a, point_item_t b);
      logic signed [32:0] d [3];
      logic [67:0] s;
      logic [67:0] m;
      d[0] = {a.px[31], a.px} - {b.px[31], b.px};
      d[1] = {a.py[31], a.py} - {b.py[31], b.py};
      d[2] = {a.pz[31], a.pz} - {b.pz[31], b.pz};
      s = '0;
      for (int k = 0; k < 3; k++) begin
        m = (d[k] < 0) ? 68'(-d[k]) : 68'(d[k]);
        s = s + m * m;
      end
      return s;
    endfunction

    function longint pull(longint acc, logic signed [31:0] tgt, logic signed [31:0] pt,
                          logic [15:0] g);
      longint gl;
      longint r;
      gl = g;
      r = acc + (longint'(tgt) - longint'(pt)) * gl;
      if (r > ACC_SAT) r = ACC_SAT;
      if (r < -ACC_SAT) r = -ACC_SAT;
      return r;
    endfunction

    function logic signed [31:0] to_q16(longint acc);
      longint q;
      q = (acc + 128) >>> 8;
      if (q > 64'sd2147483647) return 32'sh7fffffff;
      if (q < -64'sd2147483648) return 32'sh80000000;
      return q[31:0];
    endfunction

    function void solve_frame();
      longint ax [MODEL_MAX_DEF];
      longint ay [MODEL_MAX_DEF];
      longint az [MODEL_MAX_DEF];
      int n, c, best;
      logic [67:0] bd, d;
      force_rec_t r;
      n = model_pts.size();
      c = cloud_pts.size();
      for (int i = 0; i < n; i++) begin
        ax[i] = 0; ay[i] = 0; az[i] = 0;
        if (model_pts[i].occluded) continue;
        if (c > 0) begin
          best = 0;
          bd = dist_sq(model_pts[i], cloud_pts[0]);
          for (int j = 1; j < c; j++) begin
            d = dist_sq(model_pts[i], cloud_pts[j]);
            if (d < bd) begin bd = d; best = j; end  // ties keep lowest index
          end
          ax[i] = pull(ax[i], cloud_pts[best].px, model_pts[i].px, g_m2c);
          ay[i] = pull(ay[i], cloud_pts[best].py, model_pts[i].py, g_m2c);
          az[i] = pull(az[i], cloud_pts[best].pz, model_pts[i].pz, g_m2c);
        end
        ax[i] = pull(ax[i], model_pts[i].qx, model_pts[i].px, g_reg);
        ay[i] = pull(ay[i], model_pts[i].qy, model_pts[i].py, g_reg);
        az[i] = pull(az[i], model_pts[i].qz, model_pts[i].pz, g_reg);
      end
      if (n > 0) begin
        for (int j = 0; j < c; j++) begin
          best = 0;
          bd = dist_sq(cloud_pts[j], model_pts[0]);
          for (int i = 1; i < n; i++) begin
            d = dist_sq(cloud_pts[j], model_pts[i]);
            if (d < bd) begin bd = d; best = i; end
          end
          ax[best] = pull(ax[best], cloud_pts[j].px, model_pts[best].px, g_c2m);
          ay[best] = pull(ay[best], cloud_pts[j].py, model_pts[best].py, g_c2m);
          az[best] = pull(az[best], cloud_pts[j].pz, model_pts[best].pz, g_c2m);
        end
      end
      for (int i = 0; i < n; i++) begin
        r.idx = i[5:0];
        r.fx = to_q16(ax[i]);
        r.fy = to_q16(ay[i]);
        r.fz = to_q16(az[i]);
        r.fin = (i + 1 == n);
        expected_forces.insert(expected_forces.size(), r);
      end
      model_pts.delete();
      cloud_pts.delete();
    endfunction

    function void note_item(point_item_t it);
      if (!it.mode) begin
        if (model_pts.size() < MODEL_MAX_DEF) model_pts.insert(model_pts.size(), it);
      end else begin
        if (cloud_pts.size() < CLOUD_MAX_DEF) cloud_pts.insert(cloud_pts.size(), it);
        if (it.last) solve_frame();
      end
    endfunction

    function void check_force(force_rec_t got);
      force_rec_t exp_f;
      if (expected_forces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected force: idx %0d f %h %h %h final %b",
                   got.idx, got.fx, got.fy, got.fz, got.fin);
        return;
      end
      exp_f = expected_forces.pop_front();
      if (got != exp_f) begin
        mismatches++;
        if (mismatches <= 10)
          $display("force mismatch: exp idx %0d f %h %h %h final %b, got idx %0d f %h %h %h final %b",
                   exp_f.idx, exp_f.fx, exp_f.fy, exp_f.fz, exp_f.fin,
                   got.idx, got.fx, got.fy, got.fz, got.fin);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  nfe_in_if  in_ch();
  nfe_out_if out_ch();
  nfe_cfg_if cfg_ch();

  nearest_point_force_estimator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  force_tracker sb = new();

  bit hold_out;     // asks the receiver for one long stall
  bit no_gaps;      // sender runs back to back
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous overall limit
  initial begin
    #60_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result monitor: every output transfer goes to the scoreboard
  always @(posedge clk) begin
    force_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.idx = out_ch.point_index;
      got.fx = out_ch.force_x;
      got.fy = out_ch.force_y;
      got.fz = out_ch.force_z;
      got.fin = out_ch.final_res;
      sb.check_force(got);
    end
  end

  // receiver: random stall before each transfer, and one long hold-off when asked
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // mix of extremes, a small grid (ties) and full-range values
  function automatic logic signed [31:0] rand_coord(bit grid);
    if (grid) return $signed($urandom_range(0, 4) - 2) <<< 16;
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return $urandom;
    endcase
  endfunction

  // one input transfer; valid stays high when the next item follows at once
  task automatic send_point(point_item_t it);
    int gap;
    gap = (no_gaps || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.mode     <= it.mode;
    in_ch.pos_x    <= it.px;
    in_ch.pos_y    <= it.py;
    in_ch.pos_z    <= it.pz;
    in_ch.prev_x   <= it.qx;
    in_ch.prev_y   <= it.qy;
    in_ch.prev_z   <= it.qz;
    in_ch.occluded <= it.occluded;
    in_ch.last     <= it.last;
    in_ch.valid    <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_random(logic mode, logic last, bit grid);
    point_item_t it;
    it.mode = mode;
    it.px = rand_coord(grid);
    it.py = rand_coord(grid);
    it.pz = rand_coord(grid);
    it.qx = rand_coord(grid);
    it.qy = rand_coord(grid);
    it.qz = rand_coord(grid);
    it.occluded = ($urandom_range(0, 4) == 0);
    it.last = last;
    send_point(it);
  endtask

  // n model points then c cloud points, the final one marked last
  task automatic run_frame(int n, int c, bit grid);
    for (int i = 0; i < n; i++) send_random(1'b0, $urandom_range(0, 3) == 0, grid);
    for (int j = 0; j < c; j++) send_random(1'b1, j == c - 1, grid);
  endtask

  // stop offering, let all forces arrive and the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (2600) @(posedge clk);
  endtask

  task automatic write_gains(logic [15:0] m2c, logic [15:0] c2m, logic [15:0] greg);
    logic [15:0] vals [3];
    logic [7:0]  regs [3];
    vals = '{m2c, c2m, greg};
    regs = '{REG_GAIN_M2C, REG_GAIN_C2M, REG_GAIN_REG};
    drain();
    for (int k = 0; k < 3; k++) begin
      cfg_ch.index <= regs[k];
      cfg_ch.data  <= vals[k];
      cfg_ch.valid <= 1'b1;
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_gain(regs[k], vals[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    point_item_t it;
    int n, c, frames;
    bit grid;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.prev_x = '0;
    in_ch.prev_y = '0;
    in_ch.prev_z = '0;
    in_ch.occluded = 1'b0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    hold_out = 1'b0;
    no_gaps = 1'b0;
    items_sent = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset gains, extremes, occlusion, ties, last on a model item
    it = '{1'b0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
           32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0, 1'b1};
    send_point(it);
    it = '{1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
           32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0, 1'b0};
    send_point(it);
    it = '{1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh10000, 1'b1, 1'b0};
    send_point(it);
    // equidistant cloud points around the origin: tie goes to the lower index
    it = '{1'b1, 32'sh10000, 32'sh0, 32'sh0, 32'sh7fffffff, 32'sh0, 32'sh0, 1'b1, 1'b0};
    send_point(it);
    it = '{1'b1, -32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0};
    send_point(it);
    it = '{1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 1'b0, 1'b0};
    send_point(it);
    it = '{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 1'b0, 1'b1};
    send_point(it);
    // no model points: a lone last cloud point emits nothing
    run_frame(0, 1, 1'b1);
    run_frame(2, 1, 1'b1);
    run_frame(1, 3, 1'b0);
    write_gains(16'hffff, 16'hffff, 16'hffff);
    run_frame(3, 3, 1'b0);
    write_gains(16'h0000, 16'h0000, 16'h0000);
    run_frame(2, 2, 1'b0);

    // random frames under several gain settings
    frames = 0;
    while (items_sent < 290) begin
      if (frames % 12 == 11)
        write_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    ($urandom_range(0, 1)) ? 16'hffff : 16'($urandom_range(0, 1023)));
      no_gaps = ($urandom_range(0, 5) == 0);
      grid = 1'($urandom_range(0, 1));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 6);
      c = $urandom_range(1, 8);
      // long receiver hold-off while the next frame is offered
      if (frames == 5) begin
        hold_out = 1'b1;
        n = 6;
      end
      if ($urandom_range(0, 15) == 0) send_random(1'b0, 1'b1, grid); // stray model item
      run_frame(n, c, grid);
      frames++;
    end
    no_gaps = 1'b0;

    // full model store: extra model items ignored
    write_gains(16'd256, 16'd128, 16'd64);
    run_frame(66, 2, 1'b1);
    run_frame(64, 5, 1'b0);

    drain();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
